[rtl/ipd_pkg.sv]
// ----------------------------------------------------------------------------
// ipd_pkg
// shared widths, constants and inter-module types of the interval
// periodicity detector
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int unsigned MAX_EVENTS_DEF    = 64;
    localparam int unsigned INTERVAL_BITS_DEF = 48;

    localparam int unsigned TS_W      = 64;   // timestamp width
    localparam int unsigned SUM_W     = 64;   // running interval sum, divisor width
    localparam int unsigned OUT_W     = 48;   // mean and std result width
    localparam int unsigned CV_W      = 24;   // Q8.16 coefficient of variation
    localparam int unsigned CONF_W    = 17;   // Q1.16 confidence, up to 1.0
    localparam int unsigned CNT_MAX_W = 11;   // holds counts up to the largest capacity
    localparam int unsigned IV_MAX_W  = 64;   // widest stored interval
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam int unsigned MIN_EVENTS = 4;

    localparam logic [CV_W-1:0]   CV_THR_RST = 24'd19661;
    localparam logic [SUM_W-1:0]  BIAS_NS    = 64'd1000;
    localparam logic [SUM_W-1:0]  OUT_MAX    = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [CONF_W-1:0] CONF_ONE   = 17'h10000;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_CV_THRESHOLD = 1'b0,
        REG_UNMAPPED     = 1'b1
    } t_reg_idx;

    // one finished sequence handed from front to back
    typedef struct packed {
        logic                 ok;    // at least four events
        logic [CNT_MAX_W-1:0] n;     // number of stored intervals
        logic [SUM_W-1:0]     sum;   // saturated interval sum
    } t_job;

    // interval store write
    typedef struct packed {
        logic                 en;
        logic [CNT_MAX_W-1:0] addr;
        logic [IV_MAX_W-1:0]  data;
    } t_wr;

endpackage

[rtl/ipd_if.sv]
// ----------------------------------------------------------------------------
// ipd_if
// valid/ready channels for events and results
// ----------------------------------------------------------------------------
interface ipd_ev_if
    import ipd_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] event_time;
    logic            last_event;

    modport source (output valid, event_time, last_event, input ready);
    modport sink   (input valid, event_time, last_event, output ready);
endinterface

interface ipd_res_if
    import ipd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              valid_res;
    logic              periodic;
    logic [OUT_W-1:0]  mean_interval_ns;
    logic [OUT_W-1:0]  std_interval_ns;
    logic [CV_W-1:0]   variation_q16;
    logic [CONF_W-1:0] confidence_q16;

    modport source (output valid, valid_res, periodic, mean_interval_ns, std_interval_ns,
                    variation_q16, confidence_q16, input ready);
    modport sink   (input valid, valid_res, periodic, mean_interval_ns, std_interval_ns,
                    variation_q16, confidence_q16, output ready);
endinterface

[rtl/ipd_front.sv]
// ----------------------------------------------------------------------------
// ipd_front
// accepts events, forms saturated intervals, keeps count and sum,
// hands a job to the queue on the last event
// ----------------------------------------------------------------------------
module ipd_front
    import ipd_pkg::*;
#(
    parameter int unsigned MAX_EVENTS    = MAX_EVENTS_DEF,
    parameter int unsigned INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ipd_ev_if.sink i_ev,
    output t_job o_job,
    output logic o_job_valid,
    input  logic i_job_ready,
    output t_wr  o_wr,
    input  logic i_release
);

    localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
    localparam logic [TS_W-1:0] IV_MAX = (64'd1 << INTERVAL_BITS) - 64'd1;

    logic [TS_W-1:0]  r_prev;
    logic [CW-1:0]    r_cnt;
    logic [SUM_W-1:0] r_sum;
    logic             r_lock;

    logic             w_acc;
    logic             w_first;
    logic             w_room;
    logic [TS_W-1:0]  w_iv_raw;
    logic [TS_W-1:0]  w_iv;
    logic [SUM_W:0]   w_sum_add;
    logic [CW-1:0]    n_cnt;
    logic [SUM_W-1:0] n_sum;
    logic             w_ok;

    assign i_ev.ready = !r_lock && i_job_ready;
    assign w_acc      = i_ev.valid && i_ev.ready;
    assign w_first    = (r_cnt == '0);
    assign w_room     = (r_cnt < CW'(MAX_EVENTS));
    assign w_iv_raw   = i_ev.event_time - r_prev;
    assign w_iv       = (w_iv_raw > IV_MAX) ? IV_MAX : w_iv_raw;
    assign w_sum_add  = {1'b0, r_sum} + {1'b0, w_iv};

    always_comb begin
        if (w_first) begin
            n_cnt = CW'(1);
            n_sum = r_sum;
        end else if (w_room) begin
            n_cnt = r_cnt + CW'(1);
            n_sum = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
        end else begin
            n_cnt = r_cnt;
            n_sum = r_sum;
        end
    end

    assign w_ok = (n_cnt >= CW'(MIN_EVENTS));

    assign o_wr.en   = w_acc && !w_first && w_room;
    assign o_wr.addr = CNT_MAX_W'(r_cnt - CW'(1));
    assign o_wr.data = IV_MAX_W'(w_iv);

    assign o_job_valid = w_acc && i_ev.last_event;
    assign o_job.ok    = w_ok;
    assign o_job.n     = CNT_MAX_W'(n_cnt - CW'(1));
    assign o_job.sum   = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_lock <= 1'b0;
        end else if (w_acc) begin
            if (i_ev.last_event) begin
                r_prev <= '0;
                r_cnt  <= '0;
                r_sum  <= '0;
                r_lock <= w_ok;
            end else begin
                if (w_first || w_room) begin
                    r_prev <= i_ev.event_time;
                end
                r_cnt <= n_cnt;
                r_sum <= n_sum;
            end
        end else if (i_release) begin
            r_lock <= 1'b0;
        end
    end

endmodule

[rtl/ipd_queue.sv]
// ----------------------------------------------------------------------------
// ipd_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module ipd_queue
    import ipd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_valid,
    output logic o_ready,
    output t_job o_job,
    output logic o_valid,
    input  logic i_ready
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_job   = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

[rtl/ipd_div.sv]
// ----------------------------------------------------------------------------
// ipd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ipd_div
    import ipd_pkg::*;
#(
    parameter int unsigned DW = 2 * INTERVAL_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [SUM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DW-1:0]    o_quot
);

    localparam int unsigned CTW = $clog2(DW + 1);

    logic [DW-1:0]    r_q;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_div;
    logic [CTW-1:0]   r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SUM_W:0] w_sh;
    logic [SUM_W:0] w_sub;
    logic           w_ge;

    assign w_sh   = {r_rem, r_q[DW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_sub  = w_sh - {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CTW'(1);
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[SUM_W-1:0] : w_sh[SUM_W-1:0];
            r_q   <= {r_q[DW-2:0], w_ge};
        end
    end

endmodule

[rtl/ipd_back.sv]
// ----------------------------------------------------------------------------
// ipd_back
// interval store, mean, variance pass, root and coefficient of variation
// ----------------------------------------------------------------------------
module ipd_back
    import ipd_pkg::*;
#(
    parameter int unsigned MAX_EVENTS    = MAX_EVENTS_DEF,
    parameter int unsigned INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_job            i_job,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  t_wr             i_wr,
    output logic            o_release,
    input  logic [CV_W-1:0] i_cv_threshold,
    ipd_res_if.source       o_res
);

    localparam int unsigned IB  = INTERVAL_BITS;
    localparam int unsigned DW  = 2 * IB;
    localparam int unsigned AW  = $clog2(MAX_EVENTS);
    localparam int unsigned H   = (IB + 1) / 2;
    localparam int unsigned SCW = $clog2(IB + 1);
    // sum of squares: room for every interval, saturating at 128 bits
    localparam int unsigned ACC_W = (DW + AW > 128) ? 128 : DW + AW;

    typedef enum logic [3:0] {
        S_IDLE, S_MEAN, S_RD, S_DIFF, S_MUL, S_VST, S_VAR, S_SQRT, S_SAT, S_CV, S_CVW, S_OUT
    } t_state;

    logic [IB-1:0] r_mem [MAX_EVENTS];
    logic [IB-1:0] r_rdata;

    t_state               r_state;
    logic                 r_ok;
    logic [CNT_MAX_W-1:0] r_n;
    logic [AW-1:0]        r_idx;
    logic [SUM_W-1:0]     r_mean;
    logic [IB-1:0]        r_d;
    logic [2*H-1:0]       r_prod;
    logic [DW-1:0]        r_sq;
    logic [ACC_W-1:0]     r_acc;
    logic [2:0]           r_ph;
    logic [IB-1:0]        r_root;
    logic [IB:0]          r_srem;
    logic [DW-1:0]        r_sv;
    logic [SCW-1:0]       r_scnt;
    logic [OUT_W-1:0]     r_mean48;
    logic [OUT_W-1:0]     r_std48;
    logic [CV_W-1:0]      r_cv;
    logic                 r_release;
    logic                 r_ovalid;
    logic                 r_res_valid_res;
    logic                 r_res_periodic;
    logic [OUT_W-1:0]     r_res_mean;
    logic [OUT_W-1:0]     r_res_std;
    logic [CV_W-1:0]      r_res_cv;
    logic [CONF_W-1:0]    r_res_conf;

    logic             w_div_start;
    logic [ACC_W-1:0] w_div_a;
    logic [SUM_W-1:0] w_div_b;
    logic             w_div_done;
    logic [ACC_W-1:0] w_div_q;
    logic [H-1:0]     w_ma;
    logic [H-1:0]     w_mb;
    logic [2*H-1:0]   w_mp;
    logic [ACC_W:0]   w_acc_add;
    logic [IB+2:0]    w_ssh;
    logic [IB+2:0]    w_strial;
    logic             w_sge;
    logic [SUM_W-1:0] w_rd_ext;
    logic             w_load_out;
    logic             w_pass_end;

    // interval store
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data[IB-1:0];
        end
        r_rdata <= r_mem[r_idx];
    end

    ipd_div #(.DW(ACC_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    assign o_job_ready = (r_state == S_IDLE);
    assign o_release   = r_release;

    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = ACC_W'(i_job.sum);
        w_div_b     = SUM_W'(i_job.n);
        unique case (r_state)
            S_IDLE: w_div_start = i_job_valid && i_job.ok;
            S_VST: begin
                w_div_start = 1'b1;
                w_div_a     = r_acc;
                w_div_b     = SUM_W'(r_n);
            end
            S_CV: begin
                w_div_start = 1'b1;
                w_div_a     = ACC_W'({r_std48, 16'h0000});
                w_div_b     = SUM_W'(r_mean48) + BIAS_NS;
            end
            default: w_div_start = 1'b0;
        endcase
    end

    // square of the deviation in three half-width products
    always_comb begin
        unique case (r_ph)
            3'd0:    begin w_ma = r_d[H-1:0];        w_mb = r_d[H-1:0]; end
            3'd1:    begin w_ma = H'(r_d[IB-1:H]);   w_mb = r_d[H-1:0]; end
            default: begin w_ma = H'(r_d[IB-1:H]);   w_mb = H'(r_d[IB-1:H]); end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    assign w_acc_add = {1'b0, r_acc} + {1'b0, ACC_W'(r_sq)};
    assign w_ssh     = {r_srem, r_sv[DW-1:DW-2]};
    assign w_strial  = (IB+3)'({r_root, 2'b01});
    assign w_sge     = (w_ssh >= w_strial);
    assign w_rd_ext  = SUM_W'(r_rdata);
    assign w_load_out = !r_ovalid || o_res.ready;
    // last stored interval folded in, store free for the next sequence
    assign w_pass_end = (r_state == S_MUL) && (r_ph >= 3'd4)
                        && (CNT_MAX_W'(r_idx) == r_n - CNT_MAX_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_release <= 1'b0;
            r_ovalid  <= 1'b0;
            r_ok      <= 1'b0;
        end else begin
            r_release <= w_pass_end;
            if (r_ovalid && o_res.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_n  <= i_job.n;
                        r_ok <= i_job.ok;
                        r_state <= i_job.ok ? S_MEAN : S_OUT;
                    end
                end
                S_MEAN: begin
                    if (w_div_done) begin
                        r_mean  <= w_div_q[SUM_W-1:0];
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_DIFF;
                S_DIFF: begin
                    r_d     <= (w_rd_ext >= r_mean) ? IB'(w_rd_ext - r_mean)
                                                    : IB'(r_mean - w_rd_ext);
                    r_ph    <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_ph <= r_ph + 3'd1;
                    unique case (r_ph)
                        3'd0: r_prod <= w_mp;
                        3'd1: begin
                            r_sq   <= DW'(r_prod);
                            r_prod <= w_mp;
                        end
                        3'd2: begin
                            r_sq   <= r_sq + (DW'(r_prod) << (H + 1));
                            r_prod <= w_mp;
                        end
                        3'd3: r_sq <= r_sq + (DW'(r_prod) << (2 * H));
                        default: begin
                            r_acc <= w_acc_add[ACC_W] ? '1 : w_acc_add[ACC_W-1:0];
                            if (w_pass_end) begin
                                r_state <= S_VST;
                            end else begin
                                r_idx   <= r_idx + AW'(1);
                                r_state <= S_RD;
                            end
                        end
                    endcase
                end
                S_VST: r_state <= S_VAR;
                S_VAR: begin
                    if (w_div_done) begin
                        r_sv    <= w_div_q[DW-1:0];
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_scnt  <= SCW'(IB);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= w_sge ? (IB+1)'(w_ssh - w_strial) : (IB+1)'(w_ssh);
                    r_root <= {r_root[IB-2:0], w_sge};
                    r_sv   <= {r_sv[DW-3:0], 2'b00};
                    r_scnt <= r_scnt - SCW'(1);
                    if (r_scnt == SCW'(1)) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_mean48 <= (r_mean > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : r_mean[OUT_W-1:0];
                    r_std48  <= (SUM_W'(r_root) > OUT_MAX) ? OUT_MAX[OUT_W-1:0]
                                                            : OUT_W'(SUM_W'(r_root));
                    r_state  <= S_CV;
                end
                S_CV: r_state <= S_CVW;
                S_CVW: begin
                    if (w_div_done) begin
                        r_cv    <= (|w_div_q[ACC_W-1:CV_W]) ? '1 : w_div_q[CV_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_ovalid        <= 1'b1;
                        r_res_valid_res <= r_ok;
                        r_res_periodic  <= r_ok && (r_cv < i_cv_threshold);
                        r_res_mean      <= r_ok ? r_mean48 : '0;
                        r_res_std       <= r_ok ? r_std48 : '0;
                        r_res_cv        <= r_ok ? r_cv : '0;
                        r_res_conf      <= (!r_ok || (|r_cv[CV_W-1:16])) ? '0
                                           : CONF_ONE - CONF_W'(r_cv);
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid            = r_ovalid;
    assign o_res.valid_res        = r_res_valid_res;
    assign o_res.periodic         = r_res_periodic;
    assign o_res.mean_interval_ns = r_res_mean;
    assign o_res.std_interval_ns  = r_res_std;
    assign o_res.variation_q16    = r_res_cv;
    assign o_res.confidence_q16   = r_res_conf;

`ifndef SYNTHESIS
    a_release_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_release |=> !r_release)
        else $error("store release held longer than one cycle");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_res_valid_res) |-> (r_res_mean == '0 && r_res_std == '0 &&
                                             r_res_cv == '0 && !r_res_periodic))
        else $error("short sequence result carries nonzero fields");

    a_conf_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res_valid_res && r_res_cv < 24'd65536)
            |-> (r_res_conf == CONF_ONE - CONF_W'(r_res_cv)))
        else $error("confidence does not match cv");

    a_job_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> !o_job_ready)
        else $error("job taken during variance pass");
`endif

endmodule

[rtl/interval_periodicity_detector.sv]
// ----------------------------------------------------------------------------
// interval_periodicity_detector
// inter-event interval statistics and periodicity flag per event sequence
// ----------------------------------------------------------------------------
// Events come as 64-bit nanosecond timestamps, one per cycle while ready, the
// last of a sequence flagged by last_event. The front stores each interval
// (saturated to INTERVAL_BITS) and a saturating sum; at most MAX_EVENTS
// events are kept, later ones are dropped. On the last event a job goes
// through a two-entry queue to the back, which produces one result item:
// floor mean, floor std (integer root of the population variance), cv in
// Q8.16 = std*65536/(mean+1000), confidence = max(0, 1-cv) and periodic =
// cv < cv_threshold. Sequences under four events give an all-zero result.
// The back runs three passes of the shared one-bit-per-cycle divider, the
// divider and the sum of squares being 2*INTERVAL_BITS + log2(MAX_EVENTS)
// bits wide, capped at 128 (102 by default), one root step per result bit,
// and for each stored interval the read, the deviation and the half-width
// squaring. After a sequence of four or more events ends, new events wait
// until the variance pass has read the store, and while the queue is full;
// results then leave through an output register. cv_threshold lives at APB
// byte address 0, reset 19661 (about 0.3).
// ----------------------------------------------------------------------------
module interval_periodicity_detector
    import ipd_pkg::*;
#(
    parameter int unsigned MAX_EVENTS    = MAX_EVENTS_DEF,
    parameter int unsigned INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ipd_ev_if.sink             i_ev,
    ipd_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CV_W-1:0] r_cv_threshold;
    t_reg_idx        w_reg;

    t_job w_fq_job;
    logic w_fq_valid;
    logic w_fq_ready;
    t_job w_qb_job;
    logic w_qb_valid;
    logic w_qb_ready;
    t_wr  w_wr;
    logic w_release;

    // config register, single word at index 0
    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[2]);
    assign prdata = (w_reg == REG_CV_THRESHOLD) ? PDATA_W'(r_cv_threshold) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_threshold <= CV_THR_RST;
        end else if (psel && penable && pwrite && pready && w_reg == REG_CV_THRESHOLD) begin
            r_cv_threshold <= pwdata[CV_W-1:0];
        end
    end

    // front: interval capture
    ipd_front #(
        .MAX_EVENTS    (MAX_EVENTS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev        (i_ev),
        .o_job       (w_fq_job),
        .o_job_valid (w_fq_valid),
        .i_job_ready (w_fq_ready),
        .o_wr        (w_wr),
        .i_release   (w_release)
    );

    // decoupling queue
    ipd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_fq_job),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .o_job   (w_qb_job),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready)
    );

    // back: statistics
    ipd_back #(
        .MAX_EVENTS    (MAX_EVENTS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_qb_job),
        .i_job_valid    (w_qb_valid),
        .o_job_ready    (w_qb_ready),
        .i_wr           (w_wr),
        .o_release      (w_release),
        .i_cv_threshold (r_cv_threshold),
        .o_res          (o_res)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the interval periodicity detector against a built-in predictor of
// the interval statistics; event sequences of many shapes go in, random
// gaps on the event side and random stalls on the result side, and each
// result item is compared field by field with the predicted one
// ----------------------------------------------------------------------------
module testbench;
    import ipd_pkg::*;

    localparam int          CAPACITY    = 64;
    localparam logic [63:0] IV_SAT      = 64'h0000_FFFF_FFFF_FFFF;
    localparam int          ITEM_TARGET = 1600;
    localparam int          CYCLE_LIMIT = 4000000;

    // one result item as the block should emit it
    typedef struct {
        logic              valid_res;
        logic              periodic;
        logic [OUT_W-1:0]  mean_ns;
        logic [OUT_W-1:0]  std_ns;
        logic [CV_W-1:0]   cv;
        logic [CONF_W-1:0] conf;
    } t_stats;

    // tracks the sequence in progress and the statistics still owed
    class interval_scoreboard;
        logic [63:0]     prev_ts;
        int              n_events;
        logic [63:0]     iv_sum;
        logic [63:0]     iv_store [CAPACITY];
        logic [CV_W-1:0] thr;
        t_stats          owed [$];
        int              errors;

        function new();
            prev_ts  = '0;
            n_events = 0;
            iv_sum   = '0;
            thr      = CV_THR_RST;
            errors   = 0;
        endfunction

        // closes the sequence and works out its statistics
        function t_stats sequence_stats();
            t_stats      s;
            int          n;
            logic [63:0] mean, d, sd, cv, t;
            logic [127:0] acc, sq, var_q;
            logic [128:0] tmp;
            s = '{default: '0};
            if (n_events >= MIN_EVENTS) begin
                n    = n_events - 1;
                mean = iv_sum / n;
                acc  = '0;
                for (int i = 0; i < n; i++) begin
                    d   = (iv_store[i] >= mean) ? iv_store[i] - mean : mean - iv_store[i];
                    sq  = {64'd0, d} * {64'd0, d};
                    tmp = {1'b0, acc} + {1'b0, sq};
                    acc = tmp[128] ? {128{1'b1}} : tmp[127:0];
                end
                var_q = acc / n;
                sd    = '0;
                for (int b = 63; b >= 0; b--) begin
                    t = sd | (64'd1 << b);
                    if ({64'd0, t} * {64'd0, t} <= var_q) sd = t;
                end
                if (mean > IV_SAT) mean = IV_SAT;
                if (sd > IV_SAT) sd = IV_SAT;
                cv = (sd << 16) / (mean + 64'd1000);
                if (cv > 64'hFF_FFFF) cv = 64'hFF_FFFF;
                s.valid_res = 1'b1;
                s.periodic  = (cv < {40'd0, thr});
                s.mean_ns   = mean[OUT_W-1:0];
                s.std_ns    = sd[OUT_W-1:0];
                s.cv        = cv[CV_W-1:0];
                s.conf      = (cv >= 64'd65536) ? '0 : 17'(64'd65536 - cv);
            end
            prev_ts  = '0;
            n_events = 0;
            iv_sum   = '0;
            return s;
        endfunction

        // notes one accepted event item
        function void note_event(logic [63:0] ts, logic last);
            logic [63:0] iv;
            if (n_events == 0) begin
                prev_ts  = ts;
                n_events = 1;
            end else if (n_events < CAPACITY) begin
                iv = ts - prev_ts;
                if (iv > IV_SAT) iv = IV_SAT;
                iv_store[n_events-1] = iv;
                iv_sum   = (iv_sum > ~64'd0 - iv) ? ~64'd0 : iv_sum + iv;
                prev_ts  = ts;
                n_events++;
            end
            if (last) owed.push_back(sequence_stats());
        endfunction

        // compares one accepted result item with the oldest owed one
        function void check_result(t_stats got);
            t_stats e;
            if (owed.size() == 0) begin
                $error("result item with nothing owed");
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.valid_res !== e.valid_res) begin
                $error("valid_res: expected %0d, got %0d", e.valid_res, got.valid_res);
                errors++;
            end
            if (got.periodic !== e.periodic) begin
                $error("periodic: expected %0d, got %0d", e.periodic, got.periodic);
                errors++;
            end
            if (got.mean_ns !== e.mean_ns) begin
                $error("mean_interval_ns: expected %0d, got %0d", e.mean_ns, got.mean_ns);
                errors++;
            end
            if (got.std_ns !== e.std_ns) begin
                $error("std_interval_ns: expected %0d, got %0d", e.std_ns, got.std_ns);
                errors++;
            end
            if (got.cv !== e.cv) begin
                $error("variation_q16: expected %0d, got %0d", e.cv, got.cv);
                errors++;
            end
            if (got.conf !== e.conf) begin
                $error("confidence_q16: expected %0d, got %0d", e.conf, got.conf);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ipd_ev_if  ev ();
    ipd_res_if res ();

    interval_periodicity_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (ev),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    interval_scoreboard sb = new();

    always #2 i_clk = ~i_clk;

    // gap and stall ranges, zero during the stretches with no idling
    int gap_max   = 8;
    int stall_max = 8;
    int n_items   = 0;
    int cycles    = 0;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls, every accepted item checked
    initial begin
        t_stats got;
        int     stall;
        res.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
            got.valid_res = res.valid_res;
            got.periodic  = res.periodic;
            got.mean_ns   = res.mean_interval_ns;
            got.std_ns    = res.std_interval_ns;
            got.cv        = res.variation_q16;
            got.conf      = res.confidence_q16;
            sb.check_result(got);
        end
    end

    // one event item; valid stays up between items sent back to back
    task automatic send_event(logic [63:0] ts, logic last);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            ev.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ev.valid      <= 1'b1;
        ev.event_time <= ts;
        ev.last_event <= last;
        do @(posedge i_clk); while (!ev.ready);
        sb.note_event(ts, last);
        n_items++;
        @(negedge i_clk);
    endtask

    // holds events back until every owed result has come
    task automatic drain();
        ev.valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
    endtask

    // register write then read back, only while the block is idle
    task automatic write_threshold(logic [CV_W-1:0] value);
        drain();
        repeat (40) @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_CV_THRESHOLD) << 2;
        pwdata  <= {8'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CV_W-1:0] !== value) begin
            $error("cv_threshold: expected %0d, got %0d", value, prdata[CV_W-1:0]);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.thr = value;
    endtask

    // one sequence of len events; shape picks how intervals are made
    task automatic run_sequence(int len, int shape);
        logic [63:0] ts, period;
        ts     = {$urandom, $urandom};
        period = {$urandom, $urandom} >> $urandom_range(16, 63);
        for (int i = 0; i < len; i++) begin
            send_event(ts, i == len - 1);
            case (shape)
                // steady period with a little jitter
                0: ts = ts + period + $urandom_range(0, 3);
                // wide random intervals up to the saturation point and past it
                1: ts = ts + ({$urandom, $urandom} >> $urandom_range(12, 20));
                // anything at all: time going backwards, huge jumps
                2: ts = {$urandom, $urandom};
                // same time repeated
                default: ts = ts;
            endcase
        end
    endtask

    task automatic random_phase(int items);
        int len, stop;
        stop = n_items + items;
        while (n_items < stop) begin
            // stretches with no idling now and then
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            case ($urandom_range(0, 19))
                0, 1:    len = $urandom_range(1, 3);                 // too short
                2:       len = $urandom_range(CAPACITY - 4, CAPACITY + 8); // capacity
                default: len = $urandom_range(4, 14);
            endcase
            run_sequence(len, $urandom_range(0, 3));
        end
    endtask

    initial begin
        ev.valid      = 1'b0;
        ev.event_time = '0;
        ev.last_event = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: short sequences, zero intervals, extremes of time
        send_event(64'd0, 1'b1);
        send_event(64'd5, 1'b0);
        send_event(64'd9, 1'b1);
        run_sequence(3, 0);
        send_event(64'd100, 1'b0);
        send_event(64'd200, 1'b0);
        send_event(64'd300, 1'b0);
        send_event(64'd400, 1'b1);
        run_sequence(4, 3);
        // wrap from the top of the time range and backwards steps
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_event(64'd0, 1'b0);
        send_event(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
        send_event(64'h8000_0000_0000_0000, 1'b1);
        // intervals at and above the saturation point
        send_event(64'd0, 1'b0);
        send_event(64'h0000_FFFF_FFFF_FFFF, 1'b0);
        send_event(64'h0001_FFFF_FFFF_FFFF, 1'b0);
        send_event(64'h0001_FFFF_FFFF_FFFF, 1'b1);

        // default threshold, then each extreme, then random settings
        random_phase(250);
        // sender waits here for every owed result
        drain();
        random_phase(50);
        write_threshold('0);
        random_phase(250);
        write_threshold(24'hFF_FFFF);
        random_phase(250);
        write_threshold(CV_THR_RST);
        random_phase(250);
        while (n_items < ITEM_TARGET) begin
            write_threshold(($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 70000))
                                                      : 24'($urandom));
            random_phase(150);
        end

        drain();
        repeat (100) @(negedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ipd_pkg.sv
rtl/ipd_if.sv
rtl/ipd_front.sv
rtl/ipd_queue.sv
rtl/ipd_div.sv
rtl/ipd_back.sv
rtl/interval_periodicity_detector.sv
tb/testbench.sv
